>>> sv/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types, codes and sizes for the polyline arc-length point block.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned ADDR_W     = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned SEG_W      = 6;
  localparam int unsigned TOL_W      = 16;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [TOL_W-1:0]   TOL_RESET = 16'd7;
  localparam logic [PADDR_W-1:0] ADDR_TOL  = 3'd0;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PAST_END = 2'd1,
    ST_SHORT    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic [31:0]        route_position;
  } pal_in_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [SEG_W-1:0]   segment_index;
    logic               at_vertex;
    logic               at_endpoint;
  } pal_out_t;

endpackage

>>> sv/polyline_arc_length_point.sv
// ----------------------------------------------------------------------------
// polyline_arc_length_point
// Stores a 3D polyline and returns the point at a given arc length.
// ----------------------------------------------------------------------------
// One item is handled at a time; in_ready_o is high only while the sequencer
// is idle, and a finished result waits in the output register while the next
// item is taken. Work per item:
// - append: one vertex read, three squaring passes through the shared 32x32
//   multiplier and the square root unit. When the squared length overflows,
//   the length saturates without a root.
// - query: the binary search over the cumulative lengths (up to 6 probes),
//   four vertex reads, the square root and the divider, which runs once per
//   coordinate. A saturated segment length skips the root, and a zero-length
//   segment skips the divider.
// The next item is taken once the output register is free.
// Vertices and cumulative lengths live in four RAMs with registered reads. No
// clearing pass is needed, since only entries below the vertex count are read.
// vertex_tolerance sits at APB byte address 0.
// ----------------------------------------------------------------------------
module polyline_arc_length_point (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  pal_pkg::pal_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output pal_pkg::pal_out_t         out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pal_pkg::PADDR_W-1:0] paddr,
  input  logic [pal_pkg::PDATA_W-1:0] pwdata,
  output logic [pal_pkg::PDATA_W-1:0] prdata,
  output logic                      pready
);

  import pal_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WRITE,
    S_SRCH,
    S_SWAIT,
    S_SCMP,
    S_FETCH,
    S_FWAIT,
    S_FGET,
    S_SQ_MUL,
    S_SQ_ACC,
    S_SQRT,
    S_SQRT_WAIT,
    S_APP_SUM,
    S_IP_MUL,
    S_IP_DIV,
    S_IP_WAIT,
    S_FLAGS,
    S_FIN
  } state_e;

  state_e             state_q;
  pal_in_t            in_q;
  op_e                op_q;
  logic [CNT_W-1:0]   count_q;
  logic [ADDR_W-1:0]  lo_q, hi_q, rd_addr_q;
  logic [1:0]         fcnt_q, k_q;
  coord_t             vtx_q [4][3];
  coord_t             res_c_q [3];
  logic [LEN_W-1:0]   cum_q, cum_last_q, len_q;
  logic [63:0]        prod_q;
  logic [65:0]        acc_q;
  status_e            status_q;
  logic               atv_q, ate_q;
  logic               out_valid_q;
  pal_out_t           out_q;
  logic [TOL_W-1:0]   tol_q;

  // RAM ports
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [COORD_W-1:0] rd_x, rd_y, rd_z;
  logic [LEN_W-1:0]   rd_cum;

  // shared arithmetic
  logic signed [32:0] diff;
  logic               neg;
  logic [31:0]        absd;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic [31:0]        rem;
  logic               sqrt_start, sqrt_done, div_start, div_done;
  logic [31:0]        sqrt_root;
  logic [63:0]        div_quo;
  logic [ADDR_W:0]    mid;
  logic [LEN_W:0]     cum_sum;
  logic               last_seg, f_hit, l_hit;

  // Scale the quotient back onto the start coordinate and clamp it.
  function automatic coord_t interp_sat(coord_t a, logic ng, logic [63:0] q);
    logic signed [35:0] ae;
    logic signed [35:0] qe;
    logic signed [35:0] r;
    ae = 36'(a);
    qe = $signed({2'b00, q[33:0]});
    r  = ng ? (ae - qe) : (ae + qe);
    if (q > 64'h2_0000_0000) begin
      return ng ? COORD_MIN : COORD_MAX;
    end
    if (r > 36'sh0_7FFF_FFFF) begin
      return COORD_MAX;
    end
    if (r < -36'sh0_8000_0000) begin
      return COORD_MIN;
    end
    return r[31:0];
  endfunction

  assign diff  = 33'(vtx_q[1][k_q]) - 33'(vtx_q[0][k_q]);
  assign neg   = diff[32];
  assign absd  = neg ? 32'(-diff) : diff[31:0];
  assign mul_b = (state_q == S_IP_MUL) ? rem : absd;
  assign mul_p = {32'b0, absd} * {32'b0, mul_b};
  assign rem   = in_q.route_position - cum_q;
  assign mid   = ({1'b0, lo_q} + {1'b0, hi_q} + (ADDR_W+1)'(1)) >> 1;
  assign cum_sum = {1'b0, cum_q} + {1'b0, len_q};

  assign sqrt_start = (state_q == S_SQRT) && (acc_q[65:64] == 2'b00);
  assign div_start  = (state_q == S_IP_DIV) && (len_q != '0);

  assign ram_we    = (state_q == S_WRITE);
  assign ram_waddr = (op_q == OP_START) ? '0 : count_q[ADDR_W-1:0];

  assign last_seg = ({1'b0, lo_q} == (count_q - CNT_W'(2)));
  assign f_hit = (res_c_q[0] == vtx_q[2][0]) && (res_c_q[1] == vtx_q[2][1]) &&
                 (res_c_q[2] == vtx_q[2][2]);
  assign l_hit = (res_c_q[0] == vtx_q[3][0]) && (res_c_q[1] == vtx_q[3][1]) &&
                 (res_c_q[2] == vtx_q[3][2]);

  pal_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(in_q.in_x),
    .raddr_i(rd_addr_q), .rdata_o(rd_x)
  );
  pal_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(in_q.in_y),
    .raddr_i(rd_addr_q), .rdata_o(rd_y)
  );
  pal_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_z (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(in_q.in_z),
    .raddr_i(rd_addr_q), .rdata_o(rd_z)
  );
  pal_ram #(.WIDTH(LEN_W), .DEPTH(MAX_POINTS)) u_ram_cum (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(cum_q),
    .raddr_i(rd_addr_q), .rdata_o(rd_cum)
  );

  pal_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .radicand_i(acc_q[63:0]),
    .done_o(sqrt_done), .root_o(sqrt_root)
  );

  pal_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(prod_q), .divisor_i(len_q),
    .done_o(div_done), .quotient_o(div_quo)
  );

  // Configuration: one register, always ready.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TOL) ? PDATA_W'(tol_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_TOL)) begin
      tol_q <= pwdata[TOL_W-1:0];
    end
  end

  // Control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      op_q        <= OP_START;
      fcnt_q      <= '0;
      k_q         <= '0;
    end else begin
      // Drop the result once the sink takes it; FIN reloads it on its own.
      if (out_valid_q && out_ready_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            unique case (in_data_i.op)
              OP_START: begin
                op_q    <= OP_START;
                state_q <= S_WRITE;
              end
              OP_APPEND: begin
                if (count_q == '0) begin
                  // Append to an empty line behaves as a start.
                  op_q    <= OP_START;
                  state_q <= S_WRITE;
                end else if (count_q >= CNT_W'(MAX_POINTS)) begin
                  op_q    <= OP_APPEND;
                  state_q <= S_FIN;
                end else begin
                  op_q    <= OP_APPEND;
                  fcnt_q  <= '0;
                  state_q <= S_FETCH;
                end
              end
              OP_QUERY: begin
                op_q    <= OP_QUERY;
                state_q <= (count_q < CNT_W'(2)) ? S_FIN : S_SRCH;
              end
              default: begin
                op_q    <= in_data_i.op;
                state_q <= S_FIN;
              end
            endcase
          end
        end
        S_WRITE: begin
          count_q <= (op_q == OP_START) ? CNT_W'(1) : (count_q + CNT_W'(1));
          state_q <= S_FIN;
        end
        S_SRCH: begin
          if (lo_q == hi_q) begin
            fcnt_q  <= '0;
            state_q <= S_FETCH;
          end else begin
            state_q <= S_SWAIT;
          end
        end
        S_SWAIT: state_q <= S_SCMP;
        S_SCMP:  state_q <= S_SRCH;
        S_FETCH: state_q <= S_FWAIT;
        S_FWAIT: state_q <= S_FGET;
        S_FGET: begin
          if ((op_q == OP_APPEND) || (fcnt_q == 2'd3)) begin
            k_q     <= '0;
            state_q <= S_SQ_MUL;
          end else begin
            fcnt_q  <= fcnt_q + 2'd1;
            state_q <= S_FETCH;
          end
        end
        S_SQ_MUL: state_q <= S_SQ_ACC;
        S_SQ_ACC: begin
          if (k_q == 2'd2) begin
            state_q <= S_SQRT;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_SQ_MUL;
          end
        end
        S_SQRT: begin
          if (acc_q[65:64] != 2'b00) begin
            k_q     <= '0;
            state_q <= (op_q == OP_APPEND) ? S_APP_SUM : S_IP_MUL;
          end else begin
            state_q <= S_SQRT_WAIT;
          end
        end
        S_SQRT_WAIT: begin
          if (sqrt_done) begin
            k_q     <= '0;
            state_q <= (op_q == OP_APPEND) ? S_APP_SUM : S_IP_MUL;
          end
        end
        S_APP_SUM: state_q <= S_WRITE;
        S_IP_MUL:  state_q <= S_IP_DIV;
        S_IP_DIV: begin
          if (len_q == '0) begin
            k_q     <= k_q + 2'd1;
            state_q <= (k_q == 2'd2) ? S_FLAGS : S_IP_MUL;
          end else begin
            state_q <= S_IP_WAIT;
          end
        end
        S_IP_WAIT: begin
          if (div_done) begin
            k_q     <= k_q + 2'd1;
            state_q <= (k_q == 2'd2) ? S_FLAGS : S_IP_MUL;
          end
        end
        S_FLAGS: state_q <= S_FIN;
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        in_q     <= in_data_i;
        atv_q    <= 1'b0;
        ate_q    <= 1'b0;
        lo_q     <= '0;
        hi_q     <= ADDR_W'(count_q - CNT_W'(2));
        cum_q    <= '0;
        for (int i = 0; i < 3; i++) begin
          res_c_q[i] <= '0;
        end
        if (in_data_i.op == OP_APPEND && count_q >= CNT_W'(MAX_POINTS)) begin
          status_q <= ST_FULL;
        end else if (in_data_i.op == OP_QUERY && count_q < CNT_W'(2)) begin
          status_q <= ST_SHORT;
        end else begin
          status_q <= ST_OK;
        end
      end
      S_SRCH: begin
        rd_addr_q <= mid[ADDR_W-1:0];
      end
      S_SCMP: begin
        if (rd_cum <= in_q.route_position) begin
          lo_q <= rd_addr_q;
        end else begin
          hi_q <= rd_addr_q - ADDR_W'(1);
        end
      end
      S_FETCH: begin
        case (fcnt_q)
          2'd0:    rd_addr_q <= (op_q == OP_APPEND) ? ADDR_W'(count_q - CNT_W'(1)) : lo_q;
          2'd1:    rd_addr_q <= lo_q + ADDR_W'(1);
          2'd2:    rd_addr_q <= '0;
          default: rd_addr_q <= ADDR_W'(count_q - CNT_W'(1));
        endcase
      end
      S_FGET: begin
        vtx_q[fcnt_q][0] <= rd_x;
        vtx_q[fcnt_q][1] <= rd_y;
        vtx_q[fcnt_q][2] <= rd_z;
        if (fcnt_q == 2'd0) begin
          cum_q <= rd_cum;
        end
        if (fcnt_q == 2'd3) begin
          cum_last_q <= rd_cum;
        end
        if (op_q == OP_APPEND) begin
          vtx_q[1][0] <= in_q.in_x;
          vtx_q[1][1] <= in_q.in_y;
          vtx_q[1][2] <= in_q.in_z;
        end
        acc_q <= '0;
      end
      S_SQ_MUL: prod_q <= mul_p;
      S_SQ_ACC: acc_q  <= acc_q + {2'b00, prod_q};
      S_SQRT: begin
        if (acc_q[65:64] != 2'b00) begin
          len_q <= '1;
        end
      end
      S_SQRT_WAIT: begin
        if (sqrt_done) begin
          len_q <= sqrt_root;
        end
      end
      S_APP_SUM: begin
        // Saturate the running length.
        cum_q <= cum_sum[LEN_W] ? '1 : cum_sum[LEN_W-1:0];
      end
      S_IP_MUL: prod_q <= mul_p;
      S_IP_DIV: begin
        if (len_q == '0) begin
          res_c_q[k_q] <= vtx_q[0][k_q];
        end
      end
      S_IP_WAIT: begin
        if (div_done) begin
          res_c_q[k_q] <= interp_sat(vtx_q[0][k_q], neg, div_quo);
        end
      end
      S_FLAGS: begin
        status_q <= (in_q.route_position > cum_last_q) ? ST_PAST_END : ST_OK;
        atv_q    <= (rem < 32'(tol_q)) || (rem > len_q);
        ate_q    <= ((lo_q == '0) || last_seg) && (f_hit || l_hit);
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.status        <= status_q;
          out_q.out_x         <= res_c_q[0];
          out_q.out_y         <= res_c_q[1];
          out_q.out_z         <= res_c_q[2];
          out_q.segment_index <= (op_q == OP_QUERY && status_q != ST_SHORT) ?
                                 SEG_W'(lo_q) : '0;
          out_q.at_vertex     <= atv_q;
          out_q.at_endpoint   <= ate_q;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/pal_ram.sv
// ----------------------------------------------------------------------------
// pal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> sv/pal_sqrt.sv
// ----------------------------------------------------------------------------
// pal_sqrt
// Iterative integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module pal_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] rad_q;
  logic [35:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [35:0] r_sh;
  logic [35:0] trial;
  logic        take;

  assign r_sh  = {rem_q[33:0], rad_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};
  assign take  = (r_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= take ? (r_sh - trial) : r_sh;
      root_q <= {root_q[30:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> sv/pal_div.sv
// ----------------------------------------------------------------------------
// pal_div
// Iterative restoring divider, 64-bit dividend by 32-bit divisor.
// ----------------------------------------------------------------------------
module pal_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic [63:0] quo_q;
  logic [31:0] rem_q;
  logic [31:0] div_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [32:0] r_sh;
  logic        take;

  assign r_sh = {rem_q, quo_q[63]};
  assign take = (r_sh >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd63;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? 32'(r_sh - {1'b0, div_q}) : r_sh[31:0];
      quo_q <= {quo_q[62:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> sv/pal_checker.sv
// ----------------------------------------------------------------------------
// pal_checker
// Port-level assertions for the polyline arc-length point block.
// ----------------------------------------------------------------------------
module pal_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input pal_pkg::pal_out_t           out_data_o,
  input logic                        pready
);

  // Busy right after taking an item.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("block ready in the cycle after accepting an item");

  // A result never appears in the cycle right after an accept.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("result appeared without sequencer latency");

  // A waiting result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result changed or dropped while stalled");

  // Config port never stalls.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind polyline_arc_length_point pal_checker u_pal_checker (.*);

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the polyline arc-length point block: builds random
// and directed polylines, queries positions along them and compares every
// result item against a bit-accurate predictor kept in a scoreboard class.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pal_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 400;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow copy of the polyline store plus the expected results
  // --------------------------------------------------------------------------
  class polyline_scoreboard;
    coord_t      vx[MAX_POINTS];
    coord_t      vy[MAX_POINTS];
    coord_t      vz[MAX_POINTS];
    logic [31:0] cum_len[MAX_POINTS];
    int unsigned num_vertices;
    logic [15:0] tolerance;
    pal_out_t    pending_points[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      num_vertices = 0;
      tolerance    = TOL_RESET;
      mismatches   = 0;
      checked      = 0;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function automatic logic [63:0] mag(coord_t a, coord_t b);
      longint d;
      d = longint'(b) - longint'(a);
      return (d < 0) ? -d : d;
    endfunction

    // Length of segment i, floor of the Euclidean norm, saturating.
    function automatic logic [31:0] segment_length(int unsigned i);
      logic [63:0] dx, dy, dz, s, t;
      dx = mag(vx[i], vx[i+1]);
      dy = mag(vy[i], vy[i+1]);
      dz = mag(vz[i], vz[i+1]);
      s = dx * dx;
      t = s + dy * dy;
      if (t < s) return 32'hFFFF_FFFF;
      s = t;
      t = s + dz * dz;
      if (t < s) return 32'hFFFF_FFFF;
      t = root64(t);
      return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
    endfunction

    function automatic coord_t lerp_coord(coord_t a, coord_t b, logic [31:0] rem,
                                          logic [31:0] len);
      longint d, r;
      logic [63:0] q;
      if (len == 0) return a;
      d = longint'(b) - longint'(a);
      q = ((d < 0) ? -d : d) * 64'(rem);
      q = q / 64'(len);
      if (q > (64'd1 << 33)) return (d < 0) ? COORD_MIN : COORD_MAX;
      r = (d < 0) ? longint'(a) - longint'(q) : longint'(a) + longint'(q);
      if (r > longint'(COORD_MAX)) return COORD_MAX;
      if (r < longint'(COORD_MIN)) return COORD_MIN;
      return coord_t'(r);
    endfunction

    // Note an accepted input item: update the shadow store, queue the result.
    function void note_input(pal_in_t it);
      pal_out_t    res;
      int unsigned n, seg;
      logic [31:0] rem, len;
      logic [32:0] c;
      logic        first_hit, last_hit;
      res = '0;
      n   = num_vertices;
      if (it.op == OP_START || it.op == OP_APPEND) begin
        if (it.op == OP_START || n == 0) n = 0;
        else if (n >= MAX_POINTS) res.status = ST_FULL;
        if (res.status == ST_OK) begin
          vx[n] = it.in_x;
          vy[n] = it.in_y;
          vz[n] = it.in_z;
          if (n == 0) cum_len[0] = 0;
          else begin
            c = 33'(cum_len[n-1]) + 33'(segment_length(n - 1));
            cum_len[n] = c[32] ? 32'hFFFF_FFFF : c[31:0];
          end
          num_vertices = n + 1;
        end
      end else if (it.op == OP_QUERY) begin
        if (n < 2) res.status = ST_SHORT;
        else begin
          seg = 0;
          for (int unsigned i = 1; i + 1 < n; i++)
            if (cum_len[i] <= it.route_position) seg = i;
          if (it.route_position > cum_len[n-1]) res.status = ST_PAST_END;
          rem = it.route_position - cum_len[seg];
          len = segment_length(seg);
          res.at_vertex = (rem < 32'(tolerance)) || (rem > len);
          res.out_x = lerp_coord(vx[seg], vx[seg+1], rem, len);
          res.out_y = lerp_coord(vy[seg], vy[seg+1], rem, len);
          res.out_z = lerp_coord(vz[seg], vz[seg+1], rem, len);
          if (seg == 0 || seg == n - 2) begin
            first_hit = res.out_x == vx[0] && res.out_y == vy[0] && res.out_z == vz[0];
            last_hit  = res.out_x == vx[n-1] && res.out_y == vy[n-1] &&
                        res.out_z == vz[n-1];
            res.at_endpoint = first_hit || last_hit;
          end
          res.segment_index = SEG_W'(seg);
        end
      end
      pending_points = {pending_points, res};
    endfunction

    // Check one accepted result item against the oldest expectation.
    function void check_result(pal_out_t got);
      pal_out_t exp_pt;
      if (pending_points.size() == 0) begin
        $display("%0t ERROR unexpected result %p", $realtime, got);
        mismatches++;
        return;
      end
      exp_pt = pending_points.pop_front();
      checked++;
      if (got.status !== exp_pt.status)
        $display("%0t ERROR status exp %0d got %0d", $realtime, exp_pt.status, got.status);
      if (got.out_x !== exp_pt.out_x)
        $display("%0t ERROR out_x exp %h got %h", $realtime, exp_pt.out_x, got.out_x);
      if (got.out_y !== exp_pt.out_y)
        $display("%0t ERROR out_y exp %h got %h", $realtime, exp_pt.out_y, got.out_y);
      if (got.out_z !== exp_pt.out_z)
        $display("%0t ERROR out_z exp %h got %h", $realtime, exp_pt.out_z, got.out_z);
      if (got.segment_index !== exp_pt.segment_index)
        $display("%0t ERROR segment_index exp %0d got %0d", $realtime,
                 exp_pt.segment_index, got.segment_index);
      if (got.at_vertex !== exp_pt.at_vertex)
        $display("%0t ERROR at_vertex exp %b got %b", $realtime, exp_pt.at_vertex,
                 got.at_vertex);
      if (got.at_endpoint !== exp_pt.at_endpoint)
        $display("%0t ERROR at_endpoint exp %b got %b", $realtime, exp_pt.at_endpoint,
                 got.at_endpoint);
      if (got !== exp_pt) mismatches++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block
  // --------------------------------------------------------------------------
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  pal_in_t             in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  pal_out_t            out_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  polyline_arc_length_point dut (.*);

  polyline_scoreboard sb = new();

  // Idle rate in percent; zero during the calm stretch.
  int unsigned src_idle_pct = 26;
  int unsigned sink_idle_pct = 26;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned queries_sent = 0;
  int unsigned appends_full = 0;
  bit          timed_out = 0;

  // Sink: stall at random, check every accepted result item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog: count cycles with no handshake on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog: no progress for %0d cycles", $realtime, IDLE_LIMIT);
      $display("FAIL polyline_arc_length_point");
      $finish;
    end
  end

  // Send one item: random gap first, then hold valid until accepted.
  task automatic send_item(pal_in_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(it);
    items_sent++;
    if (it.op == OP_QUERY) queries_sent++;
    if (it.op == OP_APPEND && sb.pending_points[$].status == ST_FULL) appends_full++;
  endtask

  task automatic send_op(op_e op, coord_t x, coord_t y, coord_t z, logic [31:0] pos);
    pal_in_t it;
    it.op = op;
    it.in_x = x;
    it.in_y = y;
    it.in_z = z;
    it.route_position = pos;
    send_item(it);
  endtask

  // Drain: drop valid, wait for every expected result, then let the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_points.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle.
  task automatic write_tolerance(logic [15:0] tol);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_TOL; pwdata <= {16'd0, tol};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.tolerance = tol;
    @(posedge clk_i);
  endtask

  // Coordinates: mostly moderate, sometimes near the extremes.
  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0: return coord_t'($urandom());
      1: return COORD_MAX - coord_t'($urandom_range(3));
      2: return COORD_MIN + coord_t'($urandom_range(3));
      default: return coord_t'(int'($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
    endcase
  endfunction

  // Positions: anchor around stored cumulative lengths so queries hit
  // vertices, segment interiors and the area past the end.
  function automatic logic [31:0] rand_position();
    int unsigned k;
    if (sb.num_vertices == 0 || $urandom_range(9) == 0) return $urandom();
    k = $urandom_range(sb.num_vertices - 1);
    case ($urandom_range(4))
      0: return sb.cum_len[k];
      1: return sb.cum_len[k] + $urandom_range(15);
      2: return sb.cum_len[k] - $urandom_range(15);
      default: return sb.cum_len[k] + $urandom_range(32'h0100_0000);
    endcase
  endfunction

  task automatic random_phase(int unsigned count);
    int unsigned roll;
    pal_in_t     it;
    repeat (count) begin
      roll = $urandom_range(99);
      it.in_x = rand_coord();
      it.in_y = rand_coord();
      it.in_z = rand_coord();
      it.route_position = rand_position();
      if (roll < 4) it.op = OP_START;
      else if (roll < 40) it.op = OP_APPEND;
      else if (roll < 97) it.op = OP_QUERY;
      else it.op = OP_UNUSED;
      // Occasionally repeat a vertex to make zero-length segments.
      if (it.op == OP_APPEND && sb.num_vertices > 0 && $urandom_range(19) == 0) begin
        it.in_x = sb.vx[sb.num_vertices-1];
        it.in_y = sb.vy[sb.num_vertices-1];
        it.in_z = sb.vz[sb.num_vertices-1];
      end
      send_item(it);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: short-line queries, extremes, fill, unused op.
    send_op(OP_QUERY, 0, 0, 0, 32'd0);
    send_op(OP_APPEND, 32'sd65536, 0, 0, 0);
    send_op(OP_QUERY, 0, 0, 0, 32'd5);
    send_op(OP_APPEND, COORD_MAX, COORD_MIN, COORD_MAX, 0);
    send_op(OP_QUERY, 0, 0, 0, 32'd0);
    send_op(OP_QUERY, 0, 0, 0, sb.cum_len[1]);
    send_op(OP_QUERY, 0, 0, 0, 32'hFFFF_FFFF);
    send_op(OP_APPEND, COORD_MIN, COORD_MAX, COORD_MIN, 0);
    send_op(OP_APPEND, COORD_MIN, COORD_MAX, COORD_MIN, 0);
    send_op(OP_QUERY, 0, 0, 0, 32'h8000_0000);
    send_op(OP_QUERY, 0, 0, 0, 32'hFFFF_FFFF);
    send_op(OP_UNUSED, -1, -1, -1, 32'hFFFF_FFFF);
    send_op(OP_START, 0, 0, 0, 0);
    send_op(OP_APPEND, 32'sd3 << 16, 32'sd4 << 16, 0, 0);
    send_op(OP_QUERY, 0, 0, 0, 32'd5 << 16);
    send_op(OP_QUERY, 0, 0, 0, 32'd3);
    for (int i = 0; i < MAX_POINTS; i++)
      send_op(OP_APPEND, coord_t'(-i * 65536), coord_t'(i * 4096), coord_t'(i), 0);
    send_op(OP_QUERY, 0, 0, 0, sb.cum_len[MAX_POINTS-1]);
    send_op(OP_QUERY, 0, 0, 0, sb.cum_len[30] + 1);
    drain();

    // Random phases over several tolerance settings, extremes included.
    write_tolerance(16'd0);
    random_phase(300);
    drain();
    write_tolerance(16'hFFFF);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    random_phase(300);
    drain();
    src_idle_pct = 26;
    sink_idle_pct = 26;
    write_tolerance(16'($urandom()));
    random_phase(300);
    drain();
    write_tolerance(TOL_RESET);
    random_phase(300);
    drain();

    $display("Covered %0d items (%0d queries, %0d appends to a full store), %0d results checked.",
             items_sent, queries_sent, appends_full, sb.checked);
    if (sb.mismatches == 0 && sb.pending_points.size() == 0) begin
      $display("PASS polyline_arc_length_point");
    end else begin
      $display("FAIL polyline_arc_length_point");
    end
    $finish;
  end

endmodule
